// ----- src/pcpa_pkg.sv -----
// Shared types, codes and helpers for the per-CPU page allocator.
`timescale 1ns / 1ps
package pcpa_pkg;

    localparam int FRAME_W   = 15;
    localparam int COUNT_W   = 16;
    localparam int BATCH_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 15;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [BATCH_W-1:0] BATCH_MAX = 5'd16;
    localparam logic [BATCH_W-1:0] BATCH_RST = 5'd8;

    typedef enum logic [2:0] {
        MD_ALLOC = 3'd0,
        MD_FREE  = 3'd1,
        MD_INC   = 3'd2,
        MD_QUERY = 3'd3,
        MD_SEED  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_OOM  = 3'd1,
        ST_BAD  = 3'd2,
        ST_ZERO = 3'd3,
        ST_SAT  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_FRAME   = 1'd0,
        CFG_STEAL_BATCH = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]         mode;
        logic [2:0]         cpu;
        logic [FRAME_W-1:0] frame;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [FRAME_W-1:0] out_frame;
        logic [COUNT_W-1:0] ref_count;
        logic               released;
    } t_out_item;

    // list head: valid flag plus the frame on top of the list
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } t_head;

    typedef struct packed {
        logic               head_we;
        t_head              head_wdata;
        logic               link_we;
        logic [FRAME_W-1:0] link_wdata;
    } t_list_ctl;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               wr_en;
        logic               push;
    } t_alu_res;

    // zero counts as one, anything above sixteen as sixteen
    function automatic logic [BATCH_W-1:0] f_eff_batch(input logic [BATCH_W-1:0] b);
        logic [BATCH_W-1:0] r;
        r = b;
        if (b == '0) begin
            r = 5'd1;
        end else if (b > BATCH_MAX) begin
            r = BATCH_MAX;
        end
        return r;
    endfunction

endpackage

// ----- src/pcpa_alu.sv -----
// Shared count update unit: one incrementer/decrementer and the status compares.
`timescale 1ns / 1ps
module pcpa_alu (
    input  pcpa_pkg::t_mode                 i_mode,
    input  logic [pcpa_pkg::COUNT_W-1:0]    i_count,
    input  logic                            i_below_low,
    output pcpa_pkg::t_alu_res              o_res
);
    import pcpa_pkg::*;

    logic [COUNT_W-1:0] sum;
    logic               is_zero;
    logic               is_max;

    // one adder serves both increment and decrement
    assign sum     = i_count + ((i_mode == MD_FREE) ? COUNT_MAX : COUNT_W'(1));
    assign is_zero = (i_count == '0);
    assign is_max  = (i_count == COUNT_MAX);

    always_comb begin
        o_res.status = ST_OK;
        o_res.count  = i_count;
        o_res.wr_en  = 1'b0;
        o_res.push   = 1'b0;
        unique case (i_mode)
            MD_FREE: begin
                if (i_below_low) begin
                    o_res.status = ST_BAD;
                end else if (is_zero) begin
                    o_res.status = ST_ZERO;
                end else begin
                    o_res.count = sum;
                    o_res.wr_en = 1'b1;
                    o_res.push  = (sum == '0);
                end
            end
            MD_INC: begin
                if (is_max) begin
                    o_res.status = ST_SAT;
                end else begin
                    o_res.count = sum;
                    o_res.wr_en = 1'b1;
                end
            end
            MD_QUERY: begin
                o_res.status = ST_OK;
            end
            MD_SEED: begin
                if (i_below_low) begin
                    o_res.status = ST_BAD;
                end else begin
                    o_res.count = '0;
                    o_res.wr_en = 1'b1;
                    o_res.push  = 1'b1;
                end
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase
    end

endmodule

// ----- src/pcpa_refmem.sv -----
// Reference count store with its clearing pass after reset.
`timescale 1ns / 1ps
module pcpa_refmem #(
    parameter int FRAMES = 32768,
    parameter int AW     = 15
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [pcpa_pkg::COUNT_W-1:0] o_rd_data,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [pcpa_pkg::COUNT_W-1:0] i_wr_data,
    output logic                         o_clearing
);
    import pcpa_pkg::*;

    logic [COUNT_W-1:0] r_mem [FRAMES];
    logic [COUNT_W-1:0] r_rd_data;
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      n_clr_addr;
    logic               r_clr_on;
    logic               n_clr_on;

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_clr_on   = r_clr_on;
        if (r_clr_on) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(FRAMES - 1)) begin
                n_clr_on = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_on   <= 1'b1;
        end else begin
            r_clr_addr <= n_clr_addr;
            r_clr_on   <= n_clr_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_on) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_on;

endmodule

// ----- src/pcpa_lists.sv -----
// Per-CPU list heads and the next-link store that chains each free list.
`timescale 1ns / 1ps
module pcpa_lists #(
    parameter int CPUS   = 8,
    parameter int FRAMES = 32768,
    parameter int CW     = 3,
    parameter int AW     = 15
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [CW-1:0]                i_idx,
    output pcpa_pkg::t_head              o_head,
    input  pcpa_pkg::t_list_ctl          i_ctl,
    input  logic [AW-1:0]                i_link_addr,
    output logic [pcpa_pkg::FRAME_W-1:0] o_link_data
);
    import pcpa_pkg::*;

    t_head              r_heads [CPUS];
    logic [FRAME_W-1:0] r_link  [FRAMES];
    logic [FRAME_W-1:0] r_link_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CPUS; i++) begin
                r_heads[i] <= '0;
            end
        end else if (i_ctl.head_we) begin
            r_heads[i_idx] <= i_ctl.head_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.link_we) begin
            r_link[i_link_addr] <= i_ctl.link_wdata;
        end
        r_link_rd <= r_link[i_link_addr];
    end

    assign o_head      = r_heads[i_idx];
    assign o_link_data = r_link_rd;

endmodule

// ----- src/per_cpu_page_allocator_refcount_top.sv -----
// Top level: sequencer for the per-CPU page allocator with reference counts.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------------------
//  item in  | start & !busy                | i_item (mode, cpu, frame)
//  result   | o_done, one cycle, no stall  | o_result (status, out_frame,
//           |                              |   ref_count, released)
//  config   | i_cfg_valid & o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Free, increment, query and seed read the count, then pass once through the
// shared count unit. Alloc from a non-empty own list checks, then pops.
// With an empty own list, alloc scans other CPUs one per cycle, moves frames
// from the first one found (pop, push, check each), then pops.
// After reset the count store is cleared one entry a cycle, busy throughout.
// Results are never held off; o_done is a single-cycle strobe.
`timescale 1ns / 1ps
module per_cpu_page_allocator_refcount_top #(
    parameter int FRAMES = 32768,
    parameter int CPUS   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pcpa_pkg::t_in_item             i_item,
    output logic                           o_done,
    output pcpa_pkg::t_out_item            o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcpa_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import pcpa_pkg::*;

    localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_OP      = 9'b000000100,
        S_A_CHECK = 9'b000001000,
        S_A_POP   = 9'b000010000,
        S_SCAN    = 9'b000100000,
        S_MOVE    = 9'b001000000,
        S_PUSH    = 9'b010000000,
        S_NEXT    = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_mode, n_mode;
    logic [CW-1:0]      r_cpu, n_cpu;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [CW-1:0]      r_vic, n_vic;
    logic [BATCH_W-1:0] r_moved, n_moved;
    logic               r_stolen, n_stolen;
    logic [FRAME_W-1:0] r_g, n_g;
    logic [FRAME_W-1:0] r_low_frame;
    logic [BATCH_W-1:0] r_steal_batch;
    logic               r_done, n_done;
    t_out_item          r_res, n_res;

    t_head              head;
    logic [FRAME_W-1:0] link_rd;
    logic [COUNT_W-1:0] ref_rd;
    logic               clearing;
    t_alu_res           alu_res;
    logic               item_ok;
    logic               below_low;
    t_list_ctl          lctl;
    logic [CW-1:0]      hidx;
    logic [AW-1:0]      link_addr;
    logic               ref_we;
    logic [AW-1:0]      ref_waddr;
    logic [COUNT_W-1:0] ref_wdata;
    logic [AW-1:0]      ref_raddr;
    logic [BATCH_W-1:0] eff_batch;

    assign item_ok = (32'(i_item.cpu) < CPUS) && (32'(i_item.frame) < FRAMES)
                     && (i_item.mode <= MD_SEED);
    assign below_low = (r_frame < r_low_frame);
    assign eff_batch = f_eff_batch(r_steal_batch);
    assign ref_raddr = (r_state == S_IDLE) ? AW'(i_item.frame) : AW'(r_frame);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_cpu     = r_cpu;
        n_frame   = r_frame;
        n_vic     = r_vic;
        n_moved   = r_moved;
        n_stolen  = r_stolen;
        n_g       = r_g;
        n_done    = 1'b0;
        n_res     = r_res;
        lctl      = '0;
        hidx      = r_cpu;
        link_addr = AW'(head.frame);
        ref_we    = 1'b0;
        ref_waddr = AW'(r_frame);
        ref_wdata = alu_res.count;

        unique case (r_state)
            S_CLEAR: begin
                if (!clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_mode   = i_item.mode;
                    n_cpu    = CW'(i_item.cpu);
                    n_frame  = i_item.frame;
                    n_stolen = 1'b0;
                    if (!item_ok) begin
                        n_done = 1'b1;
                        n_res  = '{status: ST_BAD, out_frame: i_item.frame,
                                   ref_count: '0, released: 1'b0};
                    end else if (i_item.mode == MD_ALLOC) begin
                        n_state = S_A_CHECK;
                    end else begin
                        n_state = S_OP;
                    end
                end
            end
            S_OP: begin
                // count arrived; apply the shared unit and push if needed
                ref_we    = alu_res.wr_en;
                link_addr = AW'(r_frame);
                if (alu_res.push) begin
                    lctl.link_we    = 1'b1;
                    lctl.link_wdata = head.valid ? head.frame : r_frame;
                    lctl.head_we    = 1'b1;
                    lctl.head_wdata = '{valid: 1'b1, frame: r_frame};
                end
                n_done  = 1'b1;
                n_res   = '{status: alu_res.status, out_frame: r_frame,
                            ref_count: alu_res.count, released: alu_res.push};
                n_state = S_IDLE;
            end
            S_A_CHECK: begin
                if (head.valid) begin
                    n_state = S_A_POP;
                end else if (r_stolen) begin
                    n_done  = 1'b1;
                    n_res   = '{status: ST_OOM, out_frame: '0,
                                ref_count: '0, released: 1'b0};
                    n_state = S_IDLE;
                end else begin
                    n_vic   = '0;
                    n_state = S_SCAN;
                end
            end
            S_A_POP: begin
                lctl.head_we    = 1'b1;
                lctl.head_wdata = (link_rd == head.frame) ? '0
                                  : t_head'{valid: 1'b1, frame: link_rd};
                ref_we    = 1'b1;
                ref_waddr = AW'(head.frame);
                ref_wdata = COUNT_W'(1);
                n_done    = 1'b1;
                n_res     = '{status: ST_OK, out_frame: head.frame,
                              ref_count: COUNT_W'(1), released: 1'b0};
                n_state   = S_IDLE;
            end
            S_SCAN: begin
                hidx = r_vic;
                if ((r_vic != r_cpu) && head.valid) begin
                    n_moved = '0;
                    n_state = S_MOVE;
                end else if (r_vic == CW'(CPUS - 1)) begin
                    n_stolen = 1'b1;
                    n_state  = S_A_CHECK;
                end else begin
                    n_vic = r_vic + CW'(1);
                end
            end
            S_MOVE: begin
                // pop the victim's top frame
                hidx            = r_vic;
                lctl.head_we    = 1'b1;
                lctl.head_wdata = (link_rd == head.frame) ? '0
                                  : t_head'{valid: 1'b1, frame: link_rd};
                n_g     = head.frame;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                // push it onto the requester's list
                link_addr       = AW'(r_g);
                lctl.link_we    = 1'b1;
                lctl.link_wdata = head.valid ? head.frame : r_g;
                lctl.head_we    = 1'b1;
                lctl.head_wdata = '{valid: 1'b1, frame: r_g};
                n_moved = r_moved + BATCH_W'(1);
                n_state = S_NEXT;
            end
            S_NEXT: begin
                hidx = r_vic;
                if ((r_moved < eff_batch) && head.valid) begin
                    n_state = S_MOVE;
                end else begin
                    n_stolen = 1'b1;
                    n_state  = S_A_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_cpu    <= n_cpu;
        r_frame  <= n_frame;
        r_vic    <= n_vic;
        r_moved  <= n_moved;
        r_stolen <= n_stolen;
        r_g      <= n_g;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_frame   <= '0;
            r_steal_batch <= BATCH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LOW_FRAME:   r_low_frame   <= i_cfg_data[FRAME_W-1:0];
                CFG_STEAL_BATCH: r_steal_batch <= i_cfg_data[BATCH_W-1:0];
                default: begin
                    r_low_frame <= r_low_frame;
                end
            endcase
        end
    end

    pcpa_alu u_alu (
        .i_mode      (t_mode'(r_mode)),
        .i_count     (ref_rd),
        .i_below_low (below_low),
        .o_res       (alu_res)
    );

    pcpa_refmem #(
        .FRAMES (FRAMES),
        .AW     (AW)
    ) u_refmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (ref_raddr),
        .o_rd_data  (ref_rd),
        .i_we       (ref_we),
        .i_wr_addr  (ref_waddr),
        .i_wr_data  (ref_wdata),
        .o_clearing (clearing)
    );

    pcpa_lists #(
        .CPUS   (CPUS),
        .FRAMES (FRAMES),
        .CW     (CW),
        .AW     (AW)
    ) u_lists (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_idx       (hidx),
        .o_head      (head),
        .i_ctl       (lctl),
        .i_link_addr (link_addr),
        .o_link_data (link_rd)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && item_ok) |=> busy)
        else $error("accepted item did not make the block busy");

    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.released) |-> (o_result.ref_count == '0))
        else $error("released frame reported a nonzero count");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_POP) |=> (o_done && o_result.status == ST_OK
                                  && o_result.ref_count == COUNT_W'(1)))
        else $error("alloc pop did not report count one");

    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !clearing) |=> (r_state == S_IDLE))
        else $error("clearing pass did not return to idle");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the per-CPU page allocator with reference counts.
`timescale 1ns / 1ps
module testbench;
    import pcpa_pkg::*;

    localparam int CPUS    = 8;
    localparam int NFRAMES = 32768;
    localparam int POOL_N  = 32;
    localparam int LIMIT   = 2_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_in_item             i_item = '0;
    logic                 o_done;
    t_out_item            o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    per_cpu_page_allocator_refcount_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow allocator state
    t_head              heads [CPUS];
    logic [FRAME_W-1:0] links [NFRAMES];
    logic [COUNT_W-1:0] counts [NFRAMES];
    logic [FRAME_W-1:0] low_bound = '0;
    logic [BATCH_W-1:0] batch_cfg = BATCH_RST;

    t_in_item  pending_items [$];
    t_out_item awaited_results [$];
    int        mismatches = 0;
    int        cycle_cnt = 0;
    bit        calm = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic void push_list(int c, logic [FRAME_W-1:0] f);
        links[f] = heads[c].valid ? heads[c].frame : f;
        heads[c].valid = 1'b1;
        heads[c].frame = f;
    endfunction

    // caller guarantees the list is not empty
    function automatic logic [FRAME_W-1:0] pop_list(int c);
        logic [FRAME_W-1:0] top;
        top = heads[c].frame;
        if (links[top] == top) begin
            heads[c].valid = 1'b0;
        end else begin
            heads[c].frame = links[top];
        end
        return top;
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item          r;
        int                 c;
        int                 quota;
        int                 moved;
        logic [FRAME_W-1:0] f;
        c = it.cpu;
        f = it.frame;
        r.status    = ST_BAD;
        r.out_frame = f;
        r.ref_count = '0;
        r.released  = 1'b0;
        case (it.mode)
            MD_ALLOC: begin
                if (!heads[c].valid) begin
                    quota = (batch_cfg == '0) ? 1 :
                            ((batch_cfg > BATCH_MAX) ? int'(BATCH_MAX) : int'(batch_cfg));
                    moved = 0;
                    // steal from the first other CPU that has anything
                    for (int i = 0; i < CPUS; i++) begin
                        if (i != c && moved == 0) begin
                            while (moved < quota && heads[i].valid) begin
                                push_list(c, pop_list(i));
                                moved++;
                            end
                        end
                    end
                end
                if (heads[c].valid) begin
                    f = pop_list(c);
                    counts[f]   = 16'd1;
                    r.status    = ST_OK;
                    r.out_frame = f;
                    r.ref_count = 16'd1;
                end else begin
                    r.status    = ST_OOM;
                    r.out_frame = '0;
                end
            end
            MD_FREE: begin
                if (f < low_bound) begin
                    r.ref_count = counts[f];
                end else if (counts[f] == '0) begin
                    r.status = ST_ZERO;
                end else begin
                    counts[f]   = counts[f] - 1'b1;
                    r.ref_count = counts[f];
                    r.status    = ST_OK;
                    if (counts[f] == '0) begin
                        push_list(c, f);
                        r.released = 1'b1;
                    end
                end
            end
            MD_INC: begin
                if (counts[f] == COUNT_MAX) begin
                    r.status = ST_SAT;
                end else begin
                    counts[f] = counts[f] + 1'b1;
                    r.status  = ST_OK;
                end
                r.ref_count = counts[f];
            end
            MD_QUERY: begin
                r.status    = ST_OK;
                r.ref_count = counts[f];
            end
            MD_SEED: begin
                if (f < low_bound) begin
                    r.ref_count = counts[f];
                end else begin
                    counts[f] = '0;
                    push_list(c, f);
                    r.status   = ST_OK;
                    r.released = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_in_item make_item(logic [2:0] m, int c, int f);
        t_in_item it;
        it.mode  = m;
        it.cpu   = c[2:0];
        it.frame = f[FRAME_W-1:0];
        return it;
    endfunction

    // driver: present queued items, predict each one as it is taken
    always @(posedge i_clk) begin : drive_items
        logic     nxt_start;
        t_in_item nxt_item;
        nxt_start = start;
        nxt_item  = i_item;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            if (start && !busy) begin
                awaited_results.push_back(predict_result(i_item));
                nxt_start = 1'b0;
            end
            if (!nxt_start && pending_items.size() != 0
                && (calm || $urandom_range(99) >= 20)) begin
                nxt_start = 1'b1;
                nxt_item  = pending_items.pop_front();
            end
        end
        start  <= nxt_start;
        i_item <= nxt_item;
    end

    // monitor: compare each result strobe with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: st %0d fr %0d cnt %0d rel %0d",
                             o_result.status, o_result.out_frame, o_result.ref_count,
                             o_result.released);
                end
            end else begin
                want = awaited_results.pop_front();
                if (o_result.status !== want.status || o_result.out_frame !== want.out_frame
                    || o_result.ref_count !== want.ref_count
                    || o_result.released !== want.released) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("exp/act st %0d/%0d fr %0d/%0d cnt %0d/%0d rel %0d/%0d",
                                 want.status, o_result.status, want.out_frame,
                                 o_result.out_frame, want.ref_count, o_result.ref_count,
                                 want.released, o_result.released);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LOW_FRAME) begin
            low_bound = data;
        end else begin
            batch_cfg = data[BATCH_W-1:0];
        end
    endtask

    // hold until every queued item has been taken and answered
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || start || busy || awaited_results.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic fill_random(int n);
        logic [FRAME_W-1:0] pool [POOL_N];
        int                 base;
        int                 hot;
        int                 r;
        int                 c;
        int                 f;
        base = (low_bound > NFRAMES - POOL_N) ? NFRAMES - POOL_N :
               $urandom_range(NFRAMES - POOL_N, low_bound);
        hot = $urandom_range(CPUS - 1);
        for (int k = 0; k < POOL_N; k++) begin
            pool[k] = FRAME_W'(base + k);
        end
        // seed part of the pool onto a couple of CPUs so others must steal
        for (int k = 0; k < 12; k++) begin
            pending_items.push_back(make_item(MD_SEED, (hot + $urandom_range(1)) % CPUS,
                                              pool[k]));
        end
        for (int k = 12; k < n; k++) begin
            r = $urandom_range(99);
            c = $urandom_range(CPUS - 1);
            f = pool[$urandom_range(POOL_N - 1)];
            if (r < 8) begin
                pending_items.push_back(make_item(MD_SEED, c, f));
            end else if (r < 38) begin
                pending_items.push_back(make_item(MD_ALLOC, c, $urandom_range(NFRAMES - 1)));
            end else if (r < 68) begin
                pending_items.push_back(make_item(MD_FREE, c, f));
            end else if (r < 80) begin
                pending_items.push_back(make_item(MD_INC, c, f));
            end else if (r < 88) begin
                pending_items.push_back(make_item(MD_QUERY, c, f));
            end else begin
                pending_items.push_back(make_item(3'($urandom_range(7)), c,
                                                  $urandom_range(NFRAMES - 1)));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < CPUS; i++) begin
            heads[i] = '0;
        end
        for (int i = 0; i < NFRAMES; i++) begin
            links[i]  = '0;
            counts[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pool, bad addresses, steals, zero count, unknown modes
        write_reg(CFG_LOW_FRAME, 15'd16);
        write_reg(CFG_STEAL_BATCH, 15'd0);
        pending_items.push_back(make_item(MD_ALLOC, 0, 0));
        pending_items.push_back(make_item(MD_SEED, 0, 15));
        pending_items.push_back(make_item(MD_SEED, 0, 16));
        pending_items.push_back(make_item(MD_SEED, 0, 32767));
        pending_items.push_back(make_item(MD_SEED, 1, 17));
        pending_items.push_back(make_item(MD_SEED, 1, 18));
        pending_items.push_back(make_item(MD_SEED, 7, 20));
        pending_items.push_back(make_item(MD_QUERY, 0, 32767));
        pending_items.push_back(make_item(MD_INC, 2, 0));
        pending_items.push_back(make_item(MD_INC, 2, 15));
        pending_items.push_back(make_item(MD_FREE, 0, 15));
        pending_items.push_back(make_item(MD_QUERY, 5, 0));
        pending_items.push_back(make_item(MD_ALLOC, 0, 0));
        pending_items.push_back(make_item(MD_ALLOC, 0, 0));
        pending_items.push_back(make_item(MD_ALLOC, 0, 0));
        pending_items.push_back(make_item(MD_ALLOC, 2, 0));
        pending_items.push_back(make_item(MD_ALLOC, 3, 0));
        pending_items.push_back(make_item(MD_FREE, 3, 32767));
        pending_items.push_back(make_item(MD_FREE, 3, 32767));
        pending_items.push_back(make_item(MD_INC, 0, 16));
        pending_items.push_back(make_item(MD_FREE, 0, 16));
        pending_items.push_back(make_item(3'd5, 7, 32767));
        pending_items.push_back(make_item(3'd6, 7, 32767));
        pending_items.push_back(make_item(3'd7, 7, 32767));
        pending_items.push_back(make_item(MD_ALLOC, 4, 0));
        wait_drained();

        // back-to-back updates of one count, no idling
        write_reg(CFG_LOW_FRAME, 15'd0);
        write_reg(CFG_STEAL_BATCH, 15'd31);
        calm = 1'b1;
        for (int k = 0; k < 24; k++) begin
            pending_items.push_back(make_item(MD_INC, k % CPUS, 100));
        end
        pending_items.push_back(make_item(MD_INC, 6, 100));
        pending_items.push_back(make_item(MD_FREE, 6, 100));
        pending_items.push_back(make_item(MD_QUERY, 6, 100));
        wait_drained();
        calm = 1'b0;

        write_reg(CFG_STEAL_BATCH, 15'd16);
        fill_random(320);
        wait_drained();

        write_reg(CFG_LOW_FRAME, 15'd32767);
        write_reg(CFG_STEAL_BATCH, 15'd1);
        fill_random(320);
        wait_drained();

        write_reg(CFG_LOW_FRAME, CFG_DAT_W'($urandom_range(32767)));
        write_reg(CFG_STEAL_BATCH, CFG_DAT_W'($urandom_range(32767)));
        fill_random(320);
        wait_drained();

        write_reg(CFG_LOW_FRAME, 15'd100);
        write_reg(CFG_STEAL_BATCH, 15'd2);
        calm = 1'b1;
        fill_random(320);
        wait_drained();
        calm = 1'b0;

        write_reg(CFG_LOW_FRAME, CFG_DAT_W'($urandom_range(1024)));
        write_reg(CFG_STEAL_BATCH, CFG_DAT_W'($urandom_range(31)));
        fill_random(320);
        wait_drained();

        write_reg(CFG_LOW_FRAME, 15'd0);
        write_reg(CFG_STEAL_BATCH, 15'd8);
        fill_random(320);
        wait_drained();

        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/pcpa_pkg.sv
src/pcpa_alu.sv
src/pcpa_refmem.sv
src/pcpa_lists.sv
src/per_cpu_page_allocator_refcount_top.sv
tb/sv/testbench.sv
